>>> rtl/vcw_pkg.sv
// vcw_pkg: shared types, constants and helper functions of the vegas window engine
// used by vcw_ctrl, vcw_datapath and vegas_congestion_window; no dependencies
`default_nettype none

package vcw_pkg;

    localparam int WIN_W   = 40;
    localparam int TIME_W  = 48;
    localparam int PKT_W   = 62;
    localparam int SEG_W   = 16;
    localparam int CNT_W   = 16;
    localparam int SEGS_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;

    // shared multiplier: 48 x 48 in three 48 x 16 steps
    localparam int MUL_OP_W    = 48;
    localparam int MUL_CHUNK_W = 16;
    localparam int MUL_STEPS   = MUL_OP_W / MUL_CHUNK_W;
    localparam int MUL_ACC_W   = 2 * MUL_OP_W + MUL_CHUNK_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);

    // shared restoring divider: 88-bit dividend, 64-bit divisor
    localparam int DVD_W     = 88;
    localparam int DVS_W     = 64;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    localparam logic [SEG_W-1:0]  RST_SEGMENT_SIZE = 16'd1460;
    localparam logic [SEGS_W-1:0] RST_ALPHA        = 8'd2;
    localparam logic [SEGS_W-1:0] RST_BETA         = 8'd4;
    localparam logic [SEGS_W-1:0] RST_GAMMA        = 8'd1;
    localparam logic [WIN_W-1:0]  RST_INIT_WINDOW  = 40'd46720;
    localparam logic [WIN_W-1:0]  RST_INIT_THRESH  = 40'd14600000;
    localparam logic [TIME_W-1:0] RST_DEFAULT_SRTT = 48'd50000;
    localparam logic [MUL_OP_W-1:0] USEC_PER_SEC   = 48'd1000000;

    localparam logic [PKT_W-1:0]  PKT_MAX  = {PKT_W{1'b1}};
    localparam logic [TIME_W-1:0] RATE_MAX = {TIME_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]  FEW_SAMPLES = 16'd2;

    typedef enum logic [2:0] {
        FUNC_ACK     = 3'd0,
        FUNC_SENT    = 3'd1,
        FUNC_LOSS    = 3'd2,
        FUNC_TIMEOUT = 3'd3,
        FUNC_REINIT  = 3'd4,
        FUNC_QUERY   = 3'd5
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEGMENT_SIZE = 3'd0,
        CFG_ALPHA        = 3'd1,
        CFG_BETA         = 3'd2,
        CFG_GAMMA        = 3'd3,
        CFG_INIT_WINDOW  = 3'd4,
        CFG_INIT_THRESH  = 3'd5,
        CFG_DEFAULT_SRTT = 3'd6
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_APPLY,
        ST_EXP_MGO,
        ST_EXP_MW,
        ST_EXP_DGO,
        ST_EXP_DW,
        ST_DEN_MGO,
        ST_DEN_MW,
        ST_DIF_MGO,
        ST_DIF_MW,
        ST_DIF_DGO,
        ST_DIF_DW,
        ST_DECIDE,
        ST_RATE_MGO,
        ST_RATE_MW,
        ST_RATE_DGO,
        ST_RATE_DW,
        ST_DELIVER
    } state_t;

    typedef enum logic [1:0] {
        MUL_EXP,
        MUL_DEN,
        MUL_DIF,
        MUL_RATE
    } mul_sel_t;

    typedef enum logic [1:0] {
        DIV_EXP,
        DIV_DIF,
        DIV_RATE
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     apply;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     save_exp;
        logic     save_den;
        logic     decide;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic vegas_hit;
        logic mul_busy;
        logic div_busy;
        logic out_free;
    } sts_t;

    function automatic logic [WIN_W-1:0] add_sat40(input logic [WIN_W-1:0] a,
                                                  input logic [WIN_W-1:0] b);
        logic [WIN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WIN_W] ? {WIN_W{1'b1}} : s[WIN_W-1:0];
    endfunction

    function automatic logic [WIN_W-1:0] sub_sat40(input logic [WIN_W-1:0] a,
                                                  input logic [WIN_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

`default_nettype wire

>>> rtl/vcw_ctrl.sv
// vcw_ctrl: sequencer of the vegas window engine
// depends on vcw_pkg; drives vcw_datapath through cmd_t and reads sts_t
`default_nettype none

module vcw_ctrl
    import vcw_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_APPLY;
            ST_APPLY:    state_next = sts.vegas_hit ? ST_EXP_MGO : ST_RATE_MGO;
            ST_EXP_MGO:  state_next = ST_EXP_MW;
            ST_EXP_MW:   if (!sts.mul_busy) state_next = ST_EXP_DGO;
            ST_EXP_DGO:  state_next = ST_EXP_DW;
            ST_EXP_DW:   if (!sts.div_busy) state_next = ST_DEN_MGO;
            ST_DEN_MGO:  state_next = ST_DEN_MW;
            ST_DEN_MW:   if (!sts.mul_busy) state_next = ST_DIF_MGO;
            ST_DIF_MGO:  state_next = ST_DIF_MW;
            ST_DIF_MW:   if (!sts.mul_busy) state_next = ST_DIF_DGO;
            ST_DIF_DGO:  state_next = ST_DIF_DW;
            ST_DIF_DW:   if (!sts.div_busy) state_next = ST_DECIDE;
            ST_DECIDE:   state_next = ST_RATE_MGO;
            ST_RATE_MGO: state_next = ST_RATE_MW;
            ST_RATE_MW:  if (!sts.mul_busy) state_next = ST_RATE_DGO;
            ST_RATE_DGO: state_next = ST_RATE_DW;
            ST_RATE_DW:  if (!sts.div_busy) state_next = ST_DELIVER;
            ST_DELIVER:  if (sts.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_APPLY: cmd.apply = 1'b1;
            ST_EXP_MGO: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_EXP;
            end
            ST_EXP_DGO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_EXP;
            end
            ST_DEN_MGO: begin
                // quotient still holds the expected window here
                cmd.save_exp  = 1'b1;
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_DEN;
            end
            ST_DIF_MGO: begin
                cmd.save_den  = 1'b1;
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_DIF;
            end
            ST_DIF_DGO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DIF;
            end
            ST_DECIDE: cmd.decide = 1'b1;
            ST_RATE_MGO: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_RATE;
            end
            ST_RATE_DGO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_RATE;
            end
            ST_DELIVER: cmd.out_load = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/vcw_datapath.sv
// vcw_datapath: state registers, config registers, shared multiplier and divider,
// result register of the vegas window engine; depends on vcw_pkg
`default_nettype none

module vcw_datapath
    import vcw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cmd_t                  cmd,
    output sts_t                       sts,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [2:0]            s_func,
    input  wire logic [PKT_W-1:0]      s_packet_number,
    input  wire logic [TIME_W-1:0]     s_sent_time,
    input  wire logic [TIME_W-1:0]     s_now_time,
    input  wire logic [PKT_W-1:0]      s_acked_up_to,
    input  wire logic [SEG_W-1:0]      s_data_size,
    input  wire logic [TIME_W-1:0]     s_min_rtt,
    input  wire logic [TIME_W-1:0]     s_smoothed_rtt,
    input  wire logic                  s_in_recovery,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [WIN_W-1:0]           m_window,
    output logic [WIN_W-1:0]           m_slow_start_threshold,
    output logic                       m_in_slow_start,
    output logic [TIME_W-1:0]          m_pacing_rate
);

    // configuration
    logic [SEG_W-1:0]  seg_reg;
    logic [SEGS_W-1:0] alpha_reg, beta_reg, gamma_reg;
    logic [WIN_W-1:0]  init_win_reg, init_thr_reg;
    logic [TIME_W-1:0] dflt_srtt_reg;

    // latched event
    logic [2:0]        func_reg;
    logic [PKT_W-1:0]  pkt_reg, acked_reg;
    logic [TIME_W-1:0] sent_reg, now_reg, base_reg, srtt_in_reg;
    logic [SEG_W-1:0]  data_reg;
    logic              rec_reg;

    // engine state
    logic [WIN_W-1:0]  win_reg, win_next, thr_reg, thr_next;
    logic [TIME_W-1:0] rmin_reg, rmin_next, rr_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PKT_W-1:0]  bound_reg, bound_next, last_reg, last_next;
    logic [DVD_W-1:0]  exp_reg;
    logic [DVS_W-1:0]  den_reg;

    // multiplier
    logic                 mul_busy_reg;
    logic [MUL_CNT_W-1:0] mul_cnt_reg;
    logic [MUL_OP_W-1:0]  mul_a_reg, mul_b_reg, mul_a_sel, mul_b_sel;
    logic [MUL_ACC_W-1:0] acc_reg;
    logic [MUL_OP_W+MUL_CHUNK_W-1:0] mul_pp;
    logic [2*MUL_OP_W-1:0] prod;

    // divider
    logic                 div_busy_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DVD_W-1:0]     dvd_reg, quo_reg;
    logic [DVS_W-1:0]     dvs_reg, dvs_sel, rem_reg;
    logic [DVS_W:0]       trial;
    logic                 trial_ge;

    // result
    logic              m_valid_reg;
    logic [WIN_W-1:0]  out_win_reg, out_thr_reg;
    logic              out_slow_reg;
    logic [TIME_W-1:0] out_rate_reg;

    // ---------------- event update ----------------
    logic              slow_cur;
    logic [TIME_W-1:0] rtt, rmin_upd;
    logic [CNT_W-1:0]  cnt_upd;
    logic              round_end;
    logic [PKT_W-1:0]  bound_upd;
    logic [WIN_W-1:0]  seg40, two_seg, data40, reno_win, loss_win;
    logic [TIME_W-1:0] base_nz, seg48;

    assign slow_cur  = win_reg < thr_reg;
    assign rtt       = (now_reg > sent_reg) ? (now_reg - sent_reg) : '0;
    assign rmin_upd  = (cnt_reg == '0 || rtt < rmin_reg) ? rtt : rmin_reg;
    assign cnt_upd   = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign round_end = acked_reg >= bound_reg;
    assign bound_upd = (last_reg == PKT_MAX) ? last_reg : last_reg + 1'b1;
    assign seg40     = {{(WIN_W-SEG_W){1'b0}}, seg_reg};
    assign two_seg   = {{(WIN_W-SEG_W-1){1'b0}}, seg_reg, 1'b0};
    assign data40    = {{(WIN_W-SEG_W){1'b0}}, data_reg};
    assign reno_win  = add_sat40(win_reg, slow_cur ? data40 : seg40);
    assign loss_win  = sub_sat40(win_reg, seg40);
    assign base_nz   = (base_reg == '0) ? {{(TIME_W-1){1'b0}}, 1'b1} : base_reg;
    assign seg48     = (seg_reg == '0) ? {{(TIME_W-1){1'b0}}, 1'b1}
                                       : {{(TIME_W-SEG_W){1'b0}}, seg_reg};

    assign sts.vegas_hit = (func_reg == FUNC_ACK) && round_end && (cnt_upd > FEW_SAMPLES);

    // ---------------- round decision ----------------
    logic             diff_hi, d_gt_g, d_gt_b, d_lt_a;
    logic [DVD_W:0]   e1;
    logic [WIN_W-1:0] dec_win, dec_thr, dec_win_fl;

    assign diff_hi = |quo_reg[DVD_W-1:SEGS_W];
    assign d_gt_g  = diff_hi || (quo_reg[SEGS_W-1:0] > gamma_reg);
    assign d_gt_b  = diff_hi || (quo_reg[SEGS_W-1:0] > beta_reg);
    assign d_lt_a  = !diff_hi && (quo_reg[SEGS_W-1:0] < alpha_reg);
    assign e1      = {1'b0, exp_reg} + 1'b1;

    always_comb begin
        dec_win = win_reg;
        dec_thr = thr_reg;
        if (d_gt_g && slow_cur) begin
            if (e1 < {{(DVD_W+1-WIN_W){1'b0}}, win_reg}) begin
                dec_win = e1[WIN_W-1:0];
            end
            if (dec_win < thr_reg) begin
                dec_thr = dec_win;
            end
        end else if (slow_cur) begin
            dec_win = add_sat40(win_reg, data40);
        end else if (d_gt_b) begin
            dec_win = loss_win;
            if (loss_win < thr_reg) begin
                dec_thr = loss_win;
            end
        end else if (d_lt_a) begin
            dec_win = add_sat40(win_reg, seg40);
        end
        dec_win_fl = (dec_win < two_seg) ? two_seg : dec_win;
    end

    always_comb begin
        win_next   = win_reg;
        thr_next   = thr_reg;
        rmin_next  = rmin_reg;
        cnt_next   = cnt_reg;
        bound_next = bound_reg;
        last_next  = last_reg;
        if (cmd.apply) begin
            case (func_t'(func_reg))
                FUNC_ACK: begin
                    if (round_end) begin
                        bound_next = bound_upd;
                        rmin_next  = '0;
                        cnt_next   = '0;
                        if (cnt_upd <= FEW_SAMPLES) begin
                            win_next = reno_win;
                        end
                    end else begin
                        rmin_next = rmin_upd;
                        cnt_next  = cnt_upd;
                        win_next  = reno_win;
                    end
                end
                FUNC_SENT: last_next = pkt_reg;
                FUNC_LOSS: begin
                    win_next = loss_win;
                    thr_next = loss_win >> 1;
                end
                FUNC_TIMEOUT: begin
                    thr_next   = win_reg >> 1;
                    win_next   = two_seg;
                    rmin_next  = '0;
                    cnt_next   = '0;
                    bound_next = '0;
                    last_next  = '0;
                end
                FUNC_REINIT: begin
                    win_next   = init_win_reg;
                    thr_next   = init_thr_reg;
                    rmin_next  = '0;
                    cnt_next   = '0;
                    bound_next = '0;
                    last_next  = '0;
                end
                default: ;
            endcase
        end else if (cmd.decide) begin
            win_next = dec_win_fl;
            thr_next = dec_thr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg       <= RST_SEGMENT_SIZE;
            alpha_reg     <= RST_ALPHA;
            beta_reg      <= RST_BETA;
            gamma_reg     <= RST_GAMMA;
            init_win_reg  <= RST_INIT_WINDOW;
            init_thr_reg  <= RST_INIT_THRESH;
            dflt_srtt_reg <= RST_DEFAULT_SRTT;
            win_reg       <= RST_INIT_WINDOW;
            thr_reg       <= RST_INIT_THRESH;
            rmin_reg      <= '0;
            cnt_reg       <= '0;
            bound_reg     <= '0;
            last_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SEGMENT_SIZE: seg_reg       <= cfg_data[SEG_W-1:0];
                    CFG_ALPHA:        alpha_reg     <= cfg_data[SEGS_W-1:0];
                    CFG_BETA:         beta_reg      <= cfg_data[SEGS_W-1:0];
                    CFG_GAMMA:        gamma_reg     <= cfg_data[SEGS_W-1:0];
                    CFG_INIT_WINDOW:  init_win_reg  <= cfg_data[WIN_W-1:0];
                    CFG_INIT_THRESH:  init_thr_reg  <= cfg_data[WIN_W-1:0];
                    CFG_DEFAULT_SRTT: dflt_srtt_reg <= cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            win_reg   <= win_next;
            thr_reg   <= thr_next;
            rmin_reg  <= rmin_next;
            cnt_reg   <= cnt_next;
            bound_reg <= bound_next;
            last_reg  <= last_next;
        end
    end

    // event payload and intermediate results
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg    <= s_func;
            pkt_reg     <= s_packet_number;
            sent_reg    <= s_sent_time;
            now_reg     <= s_now_time;
            acked_reg   <= s_acked_up_to;
            data_reg    <= s_data_size;
            base_reg    <= s_min_rtt;
            srtt_in_reg <= s_smoothed_rtt;
            rec_reg     <= s_in_recovery;
        end
        if (cmd.apply) begin
            rr_reg <= rmin_upd;
        end
        if (cmd.save_exp) begin
            exp_reg <= quo_reg;
        end
        if (cmd.save_den) begin
            den_reg <= prod[DVS_W-1:0];
        end
    end

    // ---------------- multiplier ----------------
    always_comb begin
        case (cmd.mul_sel)
            MUL_EXP: begin
                mul_a_sel = {{(MUL_OP_W-WIN_W){1'b0}}, win_reg};
                mul_b_sel = base_reg;
            end
            MUL_DEN: begin
                mul_a_sel = base_nz;
                mul_b_sel = seg48;
            end
            MUL_DIF: begin
                mul_a_sel = {{(MUL_OP_W-WIN_W){1'b0}}, win_reg};
                mul_b_sel = (rr_reg > base_reg) ? (rr_reg - base_reg) : '0;
            end
            default: begin
                mul_a_sel = {{(MUL_OP_W-WIN_W){1'b0}}, win_reg};
                mul_b_sel = USEC_PER_SEC;
            end
        endcase
    end

    assign mul_pp = mul_a_reg * mul_b_reg[MUL_CHUNK_W-1:0];
    assign prod   = acc_reg[MUL_ACC_W-1:MUL_CHUNK_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_busy_reg <= 1'b0;
            mul_cnt_reg  <= '0;
        end else if (cmd.mul_start) begin
            mul_busy_reg <= 1'b1;
            mul_cnt_reg  <= '0;
        end else if (mul_busy_reg) begin
            mul_cnt_reg <= mul_cnt_reg + 1'b1;
            if (mul_cnt_reg == MUL_CNT_W'(MUL_STEPS - 1)) begin
                mul_busy_reg <= 1'b0;
            end
        end
    end

    // low chunk first; accumulator shifts right as the partial products come in
    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            mul_a_reg <= mul_a_sel;
            mul_b_reg <= mul_b_sel;
            acc_reg   <= '0;
        end else if (mul_busy_reg) begin
            mul_b_reg <= mul_b_reg >> MUL_CHUNK_W;
            acc_reg   <= {{MUL_CHUNK_W{1'b0}}, acc_reg[MUL_ACC_W-1:MUL_CHUNK_W]}
                       + {mul_pp, {(MUL_ACC_W-MUL_OP_W-MUL_CHUNK_W){1'b0}}};
        end
    end

    // ---------------- divider ----------------
    logic [TIME_W-1:0] srtt_sel;

    assign srtt_sel = (srtt_in_reg != '0) ? srtt_in_reg :
                      (dflt_srtt_reg != '0) ? dflt_srtt_reg : {{(TIME_W-1){1'b0}}, 1'b1};

    always_comb begin
        case (cmd.div_sel)
            DIV_EXP:  dvs_sel = (rr_reg == '0) ? {{(DVS_W-1){1'b0}}, 1'b1}
                                               : {{(DVS_W-TIME_W){1'b0}}, rr_reg};
            DIV_DIF:  dvs_sel = den_reg;
            default:  dvs_sel = {{(DVS_W-TIME_W){1'b0}}, srtt_sel};
        endcase
    end

    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_ge = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else if (cmd.div_start) begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end else if (div_busy_reg) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (div_cnt_reg == DIV_CNT_W'(DVD_W - 1)) begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dvd_reg <= prod[DVD_W-1:0];
            dvs_reg <= dvs_sel;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (div_busy_reg) begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= trial_ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], trial_ge};
        end
    end

    // ---------------- pacing and result ----------------
    localparam int BW_W = WIN_W + 20;
    logic             slow_fin;
    logic [BW_W-1:0]  bw;
    logic [BW_W+1:0]  rate_full;
    logic [TIME_W-1:0] rate_sat;

    assign slow_fin = win_reg < thr_reg;
    assign bw       = quo_reg[BW_W-1:0];

    always_comb begin
        if (slow_fin) begin
            rate_full = {1'b0, bw, 1'b0};
        end else if (rec_reg) begin
            rate_full = {2'b0, bw};
        end else begin
            rate_full = {2'b0, bw} + {4'b0, bw[BW_W-1:2]};
        end
        rate_sat = (|rate_full[BW_W+1:TIME_W]) ? RATE_MAX : rate_full[TIME_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_win_reg  <= win_reg;
            out_thr_reg  <= thr_reg;
            out_slow_reg <= slow_fin;
            out_rate_reg <= rate_sat;
        end
    end

    assign sts.mul_busy = mul_busy_reg;
    assign sts.div_busy = div_busy_reg;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid                = m_valid_reg;
    assign m_window               = out_win_reg;
    assign m_slow_start_threshold = out_thr_reg;
    assign m_in_slow_start        = out_slow_reg;
    assign m_pacing_rate          = out_rate_reg;

    // multiplier and divider share the product register, never run together
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_busy_reg && div_busy_reg))
        else $error("multiplier and divider busy together");

    a_mul_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |=> mul_busy_reg && mul_cnt_reg == '0)
        else $error("multiplier did not start");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_busy_reg || div_busy_reg) |-> !cmd.mul_start && !cmd.div_start)
        else $error("unit started while busy");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.out_load)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> rtl/vegas_congestion_window.sv
// vegas_congestion_window: top level of the vegas window engine
// depends on vcw_pkg, vcw_ctrl and vcw_datapath
// usage:
//   s_* channel takes one event transaction (ack, sent, loss, timeout, reinit,
//   query); m_* channel returns exactly one result transaction per event with
//   window, threshold, slow-start flag and pacing rate.
//   cfg_* channel writes the seven registers by index; always ready, takes
//   effect on the next event. write only while the engine is idle.
// sequencing:
//   one event at a time. a plain event is applied, then runs the pacing multiply
//   and the pacing divide and is delivered; the next event is accepted once its
//   result is in the output register. an ack that closes a round with more than
//   two samples adds, before the pacing steps, two 88-step divides, three 3-step
//   multiplies and a decision.
// reset:
//   aresetn low clears the engine to the initial window and threshold and
//   restores the register defaults; no result is pending after reset.
// stall:
//   a finished result sits in the output register until m_ready; the next
//   event is accepted meanwhile but its result waits until the register frees.
`default_nettype none

module vegas_congestion_window
    import vcw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [2:0]            s_func,
    input  wire logic [PKT_W-1:0]      s_packet_number,
    input  wire logic [TIME_W-1:0]     s_sent_time,
    input  wire logic [TIME_W-1:0]     s_now_time,
    input  wire logic [PKT_W-1:0]      s_acked_up_to,
    input  wire logic [SEG_W-1:0]      s_data_size,
    input  wire logic [TIME_W-1:0]     s_min_rtt,
    input  wire logic [TIME_W-1:0]     s_smoothed_rtt,
    input  wire logic                  s_in_recovery,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [WIN_W-1:0]           m_window,
    output logic [WIN_W-1:0]           m_slow_start_threshold,
    output logic                       m_in_slow_start,
    output logic [TIME_W-1:0]          m_pacing_rate
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    vcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    vcw_datapath u_datapath (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cmd                    (cmd),
        .sts                    (sts),
        .cfg_valid              (cfg_valid),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .s_func                 (s_func),
        .s_packet_number        (s_packet_number),
        .s_sent_time            (s_sent_time),
        .s_now_time             (s_now_time),
        .s_acked_up_to          (s_acked_up_to),
        .s_data_size            (s_data_size),
        .s_min_rtt              (s_min_rtt),
        .s_smoothed_rtt         (s_smoothed_rtt),
        .s_in_recovery          (s_in_recovery),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_window               (m_window),
        .m_slow_start_threshold (m_slow_start_threshold),
        .m_in_slow_start        (m_in_slow_start),
        .m_pacing_rate          (m_pacing_rate)
    );

endmodule

`default_nettype wire

>>> bench/vegas_congestion_window_tb.sv
// vegas_congestion_window_tb: self-checking bench for the vegas window engine
// depends on vcw_pkg and vegas_congestion_window; predicts every result in-bench
`default_nettype none

module vegas_congestion_window_tb;
    import vcw_pkg::*;

    localparam longint unsigned M40 = (64'd1 << 40) - 1;
    localparam longint unsigned M48 = (64'd1 << 48) - 1;
    localparam longint unsigned M62 = (64'd1 << 62) - 1;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [2:0]        func;
        logic [PKT_W-1:0]  pkt;
        logic [TIME_W-1:0] sent;
        logic [TIME_W-1:0] now;
        logic [PKT_W-1:0]  acked;
        logic [SEG_W-1:0]  size;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] srtt;
        logic              rec;
    } event_t;

    typedef struct {
        logic [WIN_W-1:0]  window;
        logic [WIN_W-1:0]  thresh;
        logic              slow;
        logic [TIME_W-1:0] rate;
    } window_state_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_func = '0;
    logic [PKT_W-1:0] s_packet_number = '0;
    logic [TIME_W-1:0] s_sent_time = '0;
    logic [TIME_W-1:0] s_now_time = '0;
    logic [PKT_W-1:0] s_acked_up_to = '0;
    logic [SEG_W-1:0] s_data_size = '0;
    logic [TIME_W-1:0] s_min_rtt = '0;
    logic [TIME_W-1:0] s_smoothed_rtt = '0;
    logic s_in_recovery = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [WIN_W-1:0] m_window;
    logic [WIN_W-1:0] m_slow_start_threshold;
    logic m_in_slow_start;
    logic [TIME_W-1:0] m_pacing_rate;

    event_t        pending_events[$];
    window_state_t expected_states[$];
    int            fail_count = 0;
    int            cycle_count = 0;
    logic          steady = 1'b0;

    // predictor copy of registers and state
    longint unsigned seg_size, alpha_segs, beta_segs, gamma_segs;
    longint unsigned init_window, init_thresh, dflt_srtt;
    longint unsigned cwnd, ssthresh, round_min, sample_cnt, round_end, last_sent;

    // stimulus bookkeeping
    longint unsigned pkt_ctr;
    longint unsigned clock_us;

    vegas_congestion_window u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_packet_number(s_packet_number), .s_sent_time(s_sent_time),
        .s_now_time(s_now_time), .s_acked_up_to(s_acked_up_to),
        .s_data_size(s_data_size), .s_min_rtt(s_min_rtt),
        .s_smoothed_rtt(s_smoothed_rtt), .s_in_recovery(s_in_recovery),
        .m_valid(m_valid), .m_ready(m_ready), .m_window(m_window),
        .m_slow_start_threshold(m_slow_start_threshold),
        .m_in_slow_start(m_in_slow_start), .m_pacing_rate(m_pacing_rate)
    );

    always #10 aclk = ~aclk;

    function automatic longint unsigned nz(input longint unsigned v);
        return (v == 0) ? 64'd1 : v;
    endfunction

    function automatic longint unsigned sub0(input longint unsigned a,
                                             input longint unsigned b);
        return (a > b) ? a - b : 64'd0;
    endfunction

    function automatic longint unsigned add_win(input longint unsigned a,
                                                input longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > M40) ? M40 : s;
    endfunction

    // floor(a*b/d) with full 128-bit product, saturating at 64 bits
    function automatic longint unsigned scale_div(input longint unsigned a,
                                                  input longint unsigned b,
                                                  input longint unsigned d);
        logic [127:0] q;
        q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
        return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
    endfunction

    function automatic void reset_window_model();
        seg_size = 64'(RST_SEGMENT_SIZE); alpha_segs = 64'(RST_ALPHA);
        beta_segs = 64'(RST_BETA); gamma_segs = 64'(RST_GAMMA);
        init_window = 64'(RST_INIT_WINDOW); init_thresh = 64'(RST_INIT_THRESH);
        dflt_srtt = 64'(RST_DEFAULT_SRTT);
        cwnd = init_window; ssthresh = init_thresh;
        round_min = 0; sample_cnt = 0; round_end = 0; last_sent = 0;
    endfunction

    function automatic void apply_register(input cfg_idx_t idx,
                                           input longint unsigned v);
        case (idx)
            CFG_SEGMENT_SIZE: seg_size = v & 16'hFFFF;
            CFG_ALPHA:        alpha_segs = v & 8'hFF;
            CFG_BETA:         beta_segs = v & 8'hFF;
            CFG_GAMMA:        gamma_segs = v & 8'hFF;
            CFG_INIT_WINDOW:  init_window = v & M40;
            CFG_INIT_THRESH:  init_thresh = v & M40;
            CFG_DEFAULT_SRTT: dflt_srtt = v & M48;
            default: ;
        endcase
    endfunction

    function automatic void grow_reno(input longint unsigned data);
        cwnd = add_win(cwnd, (cwnd < ssthresh) ? data : seg_size);
    endfunction

    function automatic void take_ack(input event_t e);
        longint unsigned rtt, expect_w, diff, e1;
        rtt = sub0(e.now, e.sent);
        if (sample_cnt == 0 || rtt < round_min) round_min = rtt;
        if (sample_cnt < 65535) sample_cnt++;
        if (e.acked >= round_end) begin
            round_end = (last_sent >= M62) ? M62 : last_sent + 1;
            if (sample_cnt <= 2) begin
                grow_reno(e.size);
            end else begin
                expect_w = scale_div(cwnd, e.base, nz(round_min));
                diff = scale_div(cwnd, sub0(round_min, e.base), nz(e.base)) / nz(seg_size);
                if (diff > gamma_segs && cwnd < ssthresh) begin
                    e1 = (expect_w == 64'hFFFF_FFFF_FFFF_FFFF) ? expect_w : expect_w + 1;
                    if (e1 < cwnd) cwnd = e1;
                    if (cwnd < ssthresh) ssthresh = cwnd;
                end else if (cwnd < ssthresh) begin
                    cwnd = add_win(cwnd, e.size);
                end else if (diff > beta_segs) begin
                    cwnd = sub0(cwnd, seg_size);
                    if (cwnd < ssthresh) ssthresh = cwnd;
                end else if (diff < alpha_segs) begin
                    cwnd = add_win(cwnd, seg_size);
                end
                if (cwnd < 2 * seg_size) cwnd = 2 * seg_size;
            end
            sample_cnt = 0;
            round_min = 0;
        end else begin
            grow_reno(e.size);
        end
    endfunction

    function automatic window_state_t predict_window(input event_t e);
        window_state_t r;
        longint unsigned srtt, bw, rate;
        case (e.func)
            FUNC_ACK:  take_ack(e);
            FUNC_SENT: last_sent = e.pkt;
            FUNC_LOSS: begin
                cwnd = sub0(cwnd, seg_size);
                ssthresh = cwnd / 2;
            end
            FUNC_TIMEOUT: begin
                ssthresh = cwnd / 2;
                round_min = 0; sample_cnt = 0; round_end = 0; last_sent = 0;
                cwnd = 2 * seg_size;
            end
            FUNC_REINIT: begin
                cwnd = init_window; ssthresh = init_thresh;
                round_min = 0; sample_cnt = 0; round_end = 0; last_sent = 0;
            end
            default: ;
        endcase
        srtt = (e.srtt != 0) ? e.srtt : nz(dflt_srtt);
        bw = (cwnd * 64'd1000000) / srtt;
        if (cwnd < ssthresh) rate = bw * 2;
        else if (e.rec) rate = bw;
        else rate = bw + bw / 4;
        if (rate > M48) rate = M48;
        r.window = cwnd[WIN_W-1:0];
        r.thresh = ssthresh[WIN_W-1:0];
        r.slow = (cwnd < ssthresh);
        r.rate = rate[TIME_W-1:0];
        return r;
    endfunction

    // event driver
    always @(posedge aclk) begin
        event_t e;
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                e.func = s_func; e.pkt = s_packet_number; e.sent = s_sent_time;
                e.now = s_now_time; e.acked = s_acked_up_to; e.size = s_data_size;
                e.base = s_min_rtt; e.srtt = s_smoothed_rtt; e.rec = s_in_recovery;
                expected_states.push_back(predict_window(e));
            end
            if (pending_events.size() > 0 && (steady || $urandom_range(99) >= 28)) begin
                e = pending_events.pop_front();
                s_valid <= 1'b1;
                s_func <= e.func; s_packet_number <= e.pkt; s_sent_time <= e.sent;
                s_now_time <= e.now; s_acked_up_to <= e.acked; s_data_size <= e.size;
                s_min_rtt <= e.base; s_smoothed_rtt <= e.srtt; s_in_recovery <= e.rec;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        window_state_t x;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_states.size() == 0) begin
                    $display("%0t: result with nothing expected: window %0d", $time, m_window);
                    fail_count++;
                end else begin
                    x = expected_states.pop_front();
                    if (m_window !== x.window) begin
                        $display("%0t: window expected %0d got %0d", $time, x.window, m_window);
                        fail_count++;
                    end
                    if (m_slow_start_threshold !== x.thresh) begin
                        $display("%0t: threshold expected %0d got %0d", $time, x.thresh,
                                 m_slow_start_threshold);
                        fail_count++;
                    end
                    if (m_in_slow_start !== x.slow) begin
                        $display("%0t: slow start expected %0b got %0b", $time, x.slow,
                                 m_in_slow_start);
                        fail_count++;
                    end
                    if (m_pacing_rate !== x.rate) begin
                        $display("%0t: pacing rate expected %0d got %0d", $time, x.rate,
                                 m_pacing_rate);
                        fail_count++;
                    end
                end
            end
            m_ready <= steady || ($urandom_range(99) >= 28);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic longint unsigned rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic event_t blank_event(input logic [2:0] f);
        event_t e;
        e.func = f; e.pkt = '0; e.sent = '0; e.now = '0; e.acked = '0;
        e.size = 16'd1460; e.base = 48'd20000; e.srtt = 48'd30000; e.rec = 1'b0;
        return e;
    endfunction

    function automatic event_t noise_event();
        event_t e;
        e.func = 3'($urandom_range(7)); e.pkt = PKT_W'(rand64());
        e.sent = TIME_W'(rand64()); e.now = TIME_W'(rand64());
        e.acked = PKT_W'(rand64()); e.size = SEG_W'($urandom);
        e.base = TIME_W'(rand64()); e.srtt = TIME_W'(rand64());
        e.rec = 1'($urandom_range(1));
        return e;
    endfunction

    function automatic void push_sent(input longint unsigned n);
        event_t e;
        e = blank_event(FUNC_SENT);
        e.pkt = n[PKT_W-1:0];
        pending_events.push_back(e);
    endfunction

    function automatic void push_ack(input longint unsigned upto, input longint unsigned rtt,
                                     input longint unsigned base);
        event_t e;
        e = blank_event(FUNC_ACK);
        clock_us += $urandom_range(1, 500);
        e.now = clock_us[TIME_W-1:0];
        e.sent = TIME_W'(clock_us - rtt);
        e.acked = upto[PKT_W-1:0];
        e.size = ($urandom_range(9) == 0) ? SEG_W'($urandom) : 16'd1460;
        e.base = base[TIME_W-1:0];
        e.srtt = ($urandom_range(19) == 0) ? 48'd0
                                            : TIME_W'(base + $urandom_range(20000));
        e.rec = $urandom_range(4) == 0;
        pending_events.push_back(e);
    endfunction

    // rounds: a burst of sends followed by its acks, plus occasional disturbances
    function automatic void push_rounds(input int count);
        int k, j, sel;
        longint unsigned base, first;
        event_t e;
        for (int n = 0; n < count; ) begin
            sel = $urandom_range(99);
            if (sel < 80) begin
                k = $urandom_range(1, 8);
                base = $urandom_range(1000, 80000);
                first = pkt_ctr;
                for (j = 0; j < k; j++) begin
                    push_sent(pkt_ctr);
                    pkt_ctr++;
                end
                for (j = 0; j < k; j++)
                    push_ack(first + j, base + $urandom_range(base / 2), base);
                n += 2 * k;
            end else if (sel < 85) begin
                pending_events.push_back(blank_event(FUNC_LOSS));
                n++;
            end else if (sel < 87) begin
                pending_events.push_back(blank_event(FUNC_TIMEOUT));
                n++;
            end else if (sel < 88) begin
                pending_events.push_back(blank_event(FUNC_REINIT));
                n++;
            end else begin
                e = noise_event();
                if (e.func == FUNC_SENT) e.pkt = {{(PKT_W-16){1'b0}}, e.pkt[15:0]};
                pending_events.push_back(e);
                n++;
            end
        end
    endfunction

    task automatic drain();
        while (pending_events.size() > 0 || s_valid || expected_states.size() > 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input longint unsigned v);
        cfg_index <= idx;
        cfg_data <= v[CFG_DATA_W-1:0];
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_register(idx, v);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_all(input longint unsigned seg, input longint unsigned a,
                             input longint unsigned b, input longint unsigned g,
                             input longint unsigned iw, input longint unsigned it,
                             input longint unsigned ds);
        write_register(CFG_SEGMENT_SIZE, seg);
        write_register(CFG_ALPHA, a);
        write_register(CFG_BETA, b);
        write_register(CFG_GAMMA, g);
        write_register(CFG_INIT_WINDOW, iw);
        write_register(CFG_INIT_THRESH, it);
        write_register(CFG_DEFAULT_SRTT, ds);
        // reinit picks up the new initial window and threshold
        pending_events.push_back(blank_event(FUNC_REINIT));
    endtask

    initial begin
        event_t e;
        reset_window_model();
        pkt_ctr = 64'd1;
        clock_us = 64'd1000000;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every operation, field extremes and corner cases
        pending_events.push_back(blank_event(FUNC_QUERY));
        for (int j = 0; j < 4; j++) push_sent(j + 1);
        push_ack(1, 30000, 20000);
        push_ack(2, 25000, 20000);
        push_ack(3, 40000, 20000);
        push_ack(4, 22000, 20000);
        e = blank_event(FUNC_ACK);   // ack arriving before its send time
        e.sent = 48'd5000; e.now = 48'd100; e.acked = 62'd10;
        pending_events.push_back(e);
        e = blank_event(FUNC_QUERY); // zero srtt falls back to the default
        e.srtt = '0; e.rec = 1'b1;
        pending_events.push_back(e);
        e = blank_event(3'd6);
        pending_events.push_back(e);
        e = blank_event(3'd7);
        e.srtt = 48'd1;
        pending_events.push_back(e);
        push_sent(M62);              // round boundary saturation
        for (int j = 0; j < 4; j++) push_ack(M62, 1000 + j, 0);
        e = noise_event();
        e.func = FUNC_QUERY; e.pkt = M62[PKT_W-1:0]; e.sent = M48[TIME_W-1:0];
        e.now = M48[TIME_W-1:0]; e.acked = M62[PKT_W-1:0];
        e.size = 16'hFFFF; e.base = M48[TIME_W-1:0]; e.srtt = M48[TIME_W-1:0];
        e.rec = 1'b1;
        pending_events.push_back(e);
        pending_events.push_back(blank_event(FUNC_LOSS));
        pending_events.push_back(blank_event(FUNC_TIMEOUT));
        pending_events.push_back(blank_event(FUNC_REINIT));
        drain();

        push_rounds(300);
        drain();

        // smallest settings but the largest initial threshold; zero default srtt
        write_all(1, 0, 0, 0, 0, M40, 0);
        push_rounds(150);
        drain();

        // largest settings but a zero initial threshold
        write_all(16'hFFFF, 255, 255, 255, M40, 0, M48);
        push_rounds(150);
        drain();

        // random settings, no idling on either side
        write_all($urandom_range(1, 65535), $urandom_range(255), $urandom_range(255),
                  $urandom_range(255), rand64() & M40, rand64() & M40, rand64() & M48);
        steady = 1'b1;
        push_rounds(200);
        drain();
        steady = 1'b0;

        write_all(1460, 1, 6, 2, 14600, 200000, 50000);
        push_rounds(300);
        drain();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
